>>> design/x86af_pkg.sv
// Shared types and constants for the x86 ALU flags and condition unit.
`default_nettype none

package x86af_pkg;

   localparam int unsigned DataWidth   = 32;
   localparam int unsigned OpWidth     = 4;
   localparam int unsigned CountWidth  = 8;
   localparam int unsigned CondWidth   = 5;
   localparam int unsigned ShiftWidth  = 5;

   localparam logic [DataWidth-1:0] SignBit = 32'h8000_0000;

   typedef enum logic [OpWidth-1:0] {
      OP_SHL  = 4'd0,
      OP_SAR  = 4'd1,
      OP_SHR  = 4'd2,
      OP_MOV  = 4'd3,
      OP_ADD  = 4'd4,
      OP_SUB  = 4'd5,
      OP_CMP  = 4'd6,
      OP_AND  = 4'd7,
      OP_TEST = 4'd8,
      OP_OR   = 4'd9,
      OP_XOR  = 4'd10,
      OP_JCC  = 4'd11
   } op_type;

   typedef enum logic [CondWidth-1:0] {
      CC_NC   = 5'd0,
      CC_NO   = 5'd1,
      CC_NP   = 5'd2,
      CC_NS   = 5'd3,
      CC_NZ   = 5'd4,
      CC_C    = 5'd5,
      CC_O    = 5'd6,
      CC_P    = 5'd7,
      CC_S    = 5'd8,
      CC_Z    = 5'd9,
      CC_A    = 5'd10,
      CC_BE   = 5'd11,
      CC_G    = 5'd12,
      CC_LE   = 5'd13,
      CC_GE   = 5'd14,
      CC_L    = 5'd15,
      CC_CXZ  = 5'd16,
      CC_ECXZ = 5'd17
   } cond_type;

   typedef struct packed {
      logic pf;
      logic zf;
      logic sf;
      logic of;
      logic cf;
   } flags_type;

   typedef struct packed {
      logic [OpWidth-1:0]    op;
      logic [DataWidth-1:0]  dst_value;
      logic [DataWidth-1:0]  src_value;
      logic [CountWidth-1:0] shift_count;
      logic [CondWidth-1:0]  cond;
   } req_type;

   typedef struct packed {
      logic [DataWidth-1:0] result_value;
      logic                 writes_back;
      flags_type            flags;
      logic                 branch_taken;
   } rsp_type;

endpackage

`default_nettype wire

>>> design/x86af_exec.sv
// Single-pass execute logic: shifter, adder, logic ops, flags and condition test.
`default_nettype none

module x86af_exec (
   input  x86af_pkg::req_type   req,
   input  x86af_pkg::flags_type flags_cur,
   output x86af_pkg::rsp_type   rsp
);
   import x86af_pkg::*;

   logic [ShiftWidth-1:0] cnt;
   logic [DataWidth:0]    shl_wide;
   logic [DataWidth:0]    shr_wide;
   logic [DataWidth:0]    sar_wide;
   logic [DataWidth:0]    sum;
   logic [DataWidth:0]    diff;
   logic [DataWidth-1:0]  and_r;
   logic [DataWidth-1:0]  r;
   logic                  cf;
   logic                  of;
   logic                  upd;
   logic                  wb;
   logic                  br;
   logic                  cnt_one;

   assign cnt      = req.shift_count[ShiftWidth-1:0];
   assign cnt_one  = (cnt == ShiftWidth'(1));
   assign shl_wide = {1'b0, req.dst_value} << cnt;
   assign shr_wide = {req.dst_value, 1'b0} >> cnt;
   assign sar_wide = $unsigned($signed({req.dst_value, 1'b0}) >>> cnt);
   assign sum      = {1'b0, req.dst_value} + {1'b0, req.src_value};
   assign diff     = {1'b0, req.dst_value} - {1'b0, req.src_value};
   assign and_r    = req.dst_value & req.src_value;

   always_comb begin
      unique case (cond_type'(req.cond))
         CC_NC:   br = !flags_cur.cf;
         CC_NO:   br = !flags_cur.of;
         CC_NP:   br = !flags_cur.pf;
         CC_NS:   br = !flags_cur.sf;
         CC_NZ:   br = !flags_cur.zf;
         CC_C:    br = flags_cur.cf;
         CC_O:    br = flags_cur.of;
         CC_P:    br = flags_cur.pf;
         CC_S:    br = flags_cur.sf;
         CC_Z:    br = flags_cur.zf;
         CC_A:    br = !flags_cur.cf && !flags_cur.zf;
         CC_BE:   br = flags_cur.cf || flags_cur.zf;
         CC_G:    br = !flags_cur.zf && (flags_cur.sf == flags_cur.of);
         CC_LE:   br = flags_cur.zf || (flags_cur.sf != flags_cur.of);
         CC_GE:   br = flags_cur.sf == flags_cur.of;
         CC_L:    br = flags_cur.sf != flags_cur.of;
         CC_CXZ:  br = (req.src_value[15:0] == 16'h0000);
         CC_ECXZ: br = (req.src_value == '0);
         default: br = 1'b0;
      endcase
   end

   always_comb begin
      r   = req.dst_value;
      wb  = 1'b0;
      cf  = flags_cur.cf;
      of  = flags_cur.of;
      upd = 1'b0;
      unique case (op_type'(req.op))
         OP_SHL: begin
            wb = 1'b1;
            if (cnt != '0) begin
               r   = shl_wide[DataWidth-1:0];
               cf  = shl_wide[DataWidth];
               upd = 1'b1;
               if (cnt_one) begin
                  of = shl_wide[DataWidth-1] ^ shl_wide[DataWidth];
               end
            end
         end
         OP_SAR: begin
            wb = 1'b1;
            if (cnt != '0) begin
               r   = sar_wide[DataWidth:1];
               cf  = sar_wide[0];
               upd = 1'b1;
               if (cnt_one) begin
                  of = 1'b0;
               end
            end
         end
         OP_SHR: begin
            wb = 1'b1;
            if (cnt != '0) begin
               r   = shr_wide[DataWidth:1];
               cf  = shr_wide[0];
               upd = 1'b1;
               if (cnt_one) begin
                  of = req.dst_value[DataWidth-1];
               end
            end
         end
         OP_MOV: begin
            r  = req.src_value;
            wb = 1'b1;
         end
         OP_ADD: begin
            r   = sum[DataWidth-1:0];
            wb  = 1'b1;
            cf  = sum[DataWidth];
            of  = |((req.dst_value ^ sum[DataWidth-1:0]) &
                    (req.src_value ^ sum[DataWidth-1:0]) & SignBit);
            upd = 1'b1;
         end
         OP_SUB, OP_CMP: begin
            if (op_type'(req.op) == OP_SUB) begin
               r  = diff[DataWidth-1:0];
               wb = 1'b1;
            end
            cf  = diff[DataWidth];
            of  = |((req.dst_value ^ req.src_value) &
                    (req.dst_value ^ diff[DataWidth-1:0]) & SignBit);
            upd = 1'b1;
         end
         OP_AND, OP_TEST: begin
            if (op_type'(req.op) == OP_AND) begin
               r  = and_r;
               wb = 1'b1;
            end
            cf  = 1'b0;
            of  = 1'b0;
            upd = 1'b1;
         end
         OP_OR: begin
            r   = req.dst_value | req.src_value;
            wb  = 1'b1;
            cf  = 1'b0;
            of  = 1'b0;
            upd = 1'b1;
         end
         OP_XOR: begin
            r   = req.dst_value ^ req.src_value;
            wb  = 1'b1;
            cf  = 1'b0;
            of  = 1'b0;
            upd = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // flags come from the logic result for TEST and the difference for CMP
   logic [DataWidth-1:0] flag_src;

   always_comb begin
      unique case (op_type'(req.op))
         OP_CMP:  flag_src = diff[DataWidth-1:0];
         OP_TEST: flag_src = and_r;
         default: flag_src = r;
      endcase
   end

   always_comb begin
      rsp.result_value = r;
      rsp.writes_back  = wb;
      rsp.branch_taken = (op_type'(req.op) == OP_JCC) ? br : 1'b0;
      if (upd) begin
         rsp.flags.cf = cf;
         rsp.flags.of = of;
         rsp.flags.sf = flag_src[DataWidth-1];
         rsp.flags.zf = (flag_src == '0);
         rsp.flags.pf = ~^flag_src[7:0];
      end else begin
         rsp.flags = flags_cur;
      end
   end

endmodule

`default_nettype wire

>>> design/x86_alu_flags_and_condition_unit.sv
// Top level: input register, execute logic, flag state and result register.
// A request is captured in the input register and its response in the result register;
// one item per cycle sustained while rsp_ready stays high, set by the single-pass
// execute logic and the flag register updated as each item leaves the input stage.
// Reset (synchronous, active high) empties both stages and clears all flags.
`default_nettype none

module x86_alu_flags_and_condition_unit (
   input  wire                                  clock,
   input  wire                                  reset,
   input  wire                                  req_valid,
   output logic                                 req_ready,
   input  wire  [x86af_pkg::OpWidth-1:0]        req_op,
   input  wire  [x86af_pkg::DataWidth-1:0]      req_dst_value,
   input  wire  [x86af_pkg::DataWidth-1:0]      req_src_value,
   input  wire  [x86af_pkg::CountWidth-1:0]     req_shift_count,
   input  wire  [x86af_pkg::CondWidth-1:0]      req_cond,
   output logic                                 rsp_valid,
   input  wire                                  rsp_ready,
   output logic [x86af_pkg::DataWidth-1:0]      rsp_result_value,
   output logic                                 rsp_writes_back,
   output logic                                 rsp_carry_flag,
   output logic                                 rsp_overflow_flag,
   output logic                                 rsp_sign_flag,
   output logic                                 rsp_zero_flag,
   output logic                                 rsp_parity_flag,
   output logic                                 rsp_branch_taken
);
   import x86af_pkg::*;

   logic      in_valid_ff;
   req_type   in_data_ff;
   logic      out_valid_ff;
   rsp_type   out_data_ff;
   flags_type flags_ff;
   rsp_type   exec_rsp;
   logic      advance;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   x86af_exec u_exec (
      .req       (in_data_ff),
      .flags_cur (flags_ff),
      .rsp       (exec_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         flags_ff     <= '0;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            flags_ff     <= exec_rsp.flags;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff.op          <= req_op;
         in_data_ff.dst_value   <= req_dst_value;
         in_data_ff.src_value   <= req_src_value;
         in_data_ff.shift_count <= req_shift_count;
         in_data_ff.cond        <= req_cond;
      end
      if (advance) begin
         out_data_ff <= exec_rsp;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_result_value  = out_data_ff.result_value;
   assign rsp_writes_back   = out_data_ff.writes_back;
   assign rsp_carry_flag    = out_data_ff.flags.cf;
   assign rsp_overflow_flag = out_data_ff.flags.of;
   assign rsp_sign_flag     = out_data_ff.flags.sf;
   assign rsp_zero_flag     = out_data_ff.flags.zf;
   assign rsp_parity_flag   = out_data_ff.flags.pf;
   assign rsp_branch_taken  = out_data_ff.branch_taken;

   // flag state only moves when an item passes into the result register
   a_flags_hold: assert property (@(posedge clock) disable iff (reset)
      (!advance) |=> $stable(flags_ff))
      else $error("flag state changed without an item advancing");

   // a pending response always carries the current flag state
   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (out_data_ff.flags == flags_ff))
      else $error("response flags differ from flag state");

   // a taken condition never writes back
   a_branch_no_wb: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_branch_taken) |-> !rsp_writes_back)
      else $error("condition item marked for write-back");

   a_reset_flags: assert property (@(posedge clock)
      reset |=> (flags_ff == '0 && !rsp_valid))
      else $error("flags or response not cleared by reset");

endmodule

`default_nettype wire

>>> tb/x86_alu_flags_and_condition_unit_tb.sv
// Self-checking bench for the x86 ALU flags unit: directed table, then random ops on both sides.
`default_nettype none

module x86_alu_flags_and_condition_unit_tb;

   import x86af_pkg::*;

   localparam logic [OpWidth-1:0]   OpUnused     = 4'd12;
   localparam logic [OpWidth-1:0]   OpUnusedTop  = 4'd15;
   localparam logic [CondWidth-1:0] CondUnused   = 5'd18;
   localparam int                   MaxReported  = 10;
   localparam int                   RandomGroups = 48;
   localparam int                   GroupSize    = 20;

   typedef struct {
      logic [OpWidth-1:0]    op;
      logic [DataWidth-1:0]  dst;
      logic [DataWidth-1:0]  src;
      logic [CountWidth-1:0] count;
      logic [CondWidth-1:0]  cc;
      bit                    typed;
      rsp_type               answer;
   } directed_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [OpWidth-1:0]    req_op = '0;
   logic [DataWidth-1:0]  req_dst_value = '0;
   logic [DataWidth-1:0]  req_src_value = '0;
   logic [CountWidth-1:0] req_shift_count = '0;
   logic [CondWidth-1:0]  req_cond = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [DataWidth-1:0]  rsp_result_value;
   logic                  rsp_writes_back;
   logic                  rsp_carry_flag;
   logic                  rsp_overflow_flag;
   logic                  rsp_sign_flag;
   logic                  rsp_zero_flag;
   logic                  rsp_parity_flag;
   logic                  rsp_branch_taken;

   flags_type        alu_flags = '0;
   rsp_type          pending_results[$];
   directed_row_type directed_rows[$];
   int               error_count = 0;
   bit               no_gaps;
   int               gap;

   x86_alu_flags_and_condition_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_dst_value     (req_dst_value),
      .req_src_value     (req_src_value),
      .req_shift_count   (req_shift_count),
      .req_cond          (req_cond),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_value  (rsp_result_value),
      .rsp_writes_back   (rsp_writes_back),
      .rsp_carry_flag    (rsp_carry_flag),
      .rsp_overflow_flag (rsp_overflow_flag),
      .rsp_sign_flag     (rsp_sign_flag),
      .rsp_zero_flag     (rsp_zero_flag),
      .rsp_parity_flag   (rsp_parity_flag),
      .rsp_branch_taken  (rsp_branch_taken)
   );

   always #2 clock = ~clock;

   function automatic flags_type status_from(input logic [DataWidth-1:0] value,
                                             input logic cf, input logic of);
      flags_type f;
      f.cf = cf;
      f.of = of;
      f.sf = value[DataWidth-1];
      f.zf = (value == '0);
      f.pf = ~^value[7:0];
      return f;
   endfunction

   function automatic logic cond_holds(input logic [CondWidth-1:0] cc,
                                       input logic [DataWidth-1:0] ecx, input flags_type f);
      case (cc)
         CC_NC:   return !f.cf;
         CC_NO:   return !f.of;
         CC_NP:   return !f.pf;
         CC_NS:   return !f.sf;
         CC_NZ:   return !f.zf;
         CC_C:    return f.cf;
         CC_O:    return f.of;
         CC_P:    return f.pf;
         CC_S:    return f.sf;
         CC_Z:    return f.zf;
         CC_A:    return !f.cf && !f.zf;
         CC_BE:   return f.cf || f.zf;
         CC_G:    return !f.zf && (f.sf == f.of);
         CC_LE:   return f.zf || (f.sf != f.of);
         CC_GE:   return f.sf == f.of;
         CC_L:    return f.sf != f.of;
         CC_CXZ:  return ecx[15:0] == 16'h0;
         CC_ECXZ: return ecx == '0;
         default: return 1'b0;
      endcase
   endfunction

   // Executes one op against the bench's own flag copy and returns the expected transfer.
   function automatic rsp_type alu_execute(input logic [OpWidth-1:0] op,
                                           input logic [DataWidth-1:0] d,
                                           input logic [DataWidth-1:0] s,
                                           input logic [CountWidth-1:0] count,
                                           input logic [CondWidth-1:0] cc);
      rsp_type              r;
      flags_type            f;
      logic [ShiftWidth-1:0] n;
      logic [DataWidth-1:0] v;
      logic                 cf;
      logic                 of;
      f = alu_flags;
      n = count[ShiftWidth-1:0];
      r.result_value = d;
      r.writes_back  = 1'b0;
      r.branch_taken = 1'b0;
      case (op)
         OP_SHL: begin
            r.writes_back = 1'b1;
            if (n != 0) begin
               r.result_value = d << n;
               cf = d[32 - int'(n)];
               of = (n == 1) ? (r.result_value[31] ^ cf) : f.of;
               f = status_from(r.result_value, cf, of);
            end
         end
         OP_SAR, OP_SHR: begin
            r.writes_back = 1'b1;
            if (n != 0) begin
               if (op == OP_SAR) r.result_value = $signed(d) >>> n;
               else r.result_value = d >> n;
               cf = d[int'(n) - 1];
               of = (n == 1) ? ((op == OP_SAR) ? 1'b0 : d[31]) : f.of;
               f = status_from(r.result_value, cf, of);
            end
         end
         OP_MOV: begin
            r.result_value = s;
            r.writes_back  = 1'b1;
         end
         OP_ADD: begin
            v = d + s;
            r.result_value = v;
            r.writes_back  = 1'b1;
            f = status_from(v, v < d, (d[31] ^ v[31]) & (s[31] ^ v[31]));
         end
         OP_SUB, OP_CMP: begin
            v = d - s;
            f = status_from(v, d < s, (d[31] ^ s[31]) & (d[31] ^ v[31]));
            if (op == OP_SUB) begin
               r.result_value = v;
               r.writes_back  = 1'b1;
            end
         end
         OP_AND, OP_TEST: begin
            v = d & s;
            f = status_from(v, 1'b0, 1'b0);
            if (op == OP_AND) begin
               r.result_value = v;
               r.writes_back  = 1'b1;
            end
         end
         OP_OR: begin
            r.result_value = d | s;
            r.writes_back  = 1'b1;
            f = status_from(r.result_value, 1'b0, 1'b0);
         end
         OP_XOR: begin
            r.result_value = d ^ s;
            r.writes_back  = 1'b1;
            f = status_from(r.result_value, 1'b0, 1'b0);
         end
         OP_JCC: r.branch_taken = cond_holds(cc, s, f);
         default: ;
      endcase
      alu_flags = f;
      r.flags = f;
      return r;
   endfunction

   function automatic logic [DataWidth-1:0] pick_operand();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         2: return SignBit;
         3: return ~SignBit;
         4: return DataWidth'($urandom_range(0, 255));
         5: return {16'($urandom), 16'h0};
         6: return DataWidth'($urandom_range(0, 65535));
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic add_row(input logic [OpWidth-1:0] op, input logic [DataWidth-1:0] dst,
                          input logic [DataWidth-1:0] src, input logic [CountWidth-1:0] count,
                          input logic [CondWidth-1:0] cc, input bit typed,
                          input rsp_type answer);
      directed_row_type row;
      row.op     = op;
      row.dst    = dst;
      row.src    = src;
      row.count  = count;
      row.cc     = cc;
      row.typed  = typed;
      row.answer = answer;
      directed_rows.push_back(row);
   endtask

   // Offers one item until transfer; readiness is sampled mid-cycle, ahead of the edge.
   task automatic send_op(input logic [OpWidth-1:0] op, input logic [DataWidth-1:0] dst,
                          input logic [DataWidth-1:0] src, input logic [CountWidth-1:0] count,
                          input logic [CondWidth-1:0] cc, input bit typed,
                          input rsp_type answer);
      rsp_type predicted;
      bit      accepted;
      req_valid       <= 1'b1;
      req_op          <= op;
      req_dst_value   <= dst;
      req_src_value   <= src;
      req_shift_count <= count;
      req_cond        <= cc;
      accepted = 1'b0;
      while (!accepted) begin
         @(negedge clock);
         accepted = req_ready;
         @(posedge clock);
      end
      predicted = alu_execute(op, dst, src, count, cc);
      pending_results.push_back(typed ? answer : predicted);
   endtask

   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   initial begin
      // typed answers: value, write-back, {pf zf sf of cf}, branch
      add_row(OP_JCC, 32'h1234_5678, 32'h0, 8'd0, CC_NC, 1'b1,
              {32'h1234_5678, 1'b0, 5'b00000, 1'b1});
      add_row(OP_JCC, 32'hFFFF_FFFF, 32'h0, 8'd0, CC_C, 1'b1,
              {32'hFFFF_FFFF, 1'b0, 5'b00000, 1'b0});
      add_row(OP_MOV, 32'h0, 32'hFFFF_FFFF, 8'd0, CC_NC, 1'b1,
              {32'hFFFF_FFFF, 1'b1, 5'b00000, 1'b0});
      add_row(OP_ADD, 32'hFFFF_FFFF, 32'h1, 8'd0, CC_NC, 1'b1,
              {32'h0000_0000, 1'b1, 5'b11001, 1'b0});
      add_row(OpUnused, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 8'd1, CC_NC, 1'b1,
              {32'hA5A5_A5A5, 1'b0, 5'b11001, 1'b0});
      add_row(OP_SUB, 32'h8000_0000, 32'h1, 8'd0, CC_NC, 1'b1,
              {32'h7FFF_FFFF, 1'b1, 5'b10010, 1'b0});
      add_row(OP_JCC, 32'h0, 32'h0, 8'd0, CC_O, 1'b1,
              {32'h0000_0000, 1'b0, 5'b10010, 1'b1});
      add_row(OpUnusedTop, 32'hFFFF_FFFF, 32'h0, 8'hFF, CC_ECXZ, 1'b0, '0);
      add_row(OP_CMP, 32'h0, 32'h1, 8'd0, CC_NC, 1'b0, '0);
      add_row(OP_ADD, 32'h7FFF_FFFF, 32'h1, 8'd0, CC_NC, 1'b0, '0);
      add_row(OP_AND, 32'hFFFF_FFFF, 32'h0, 8'd0, CC_NC, 1'b0, '0);
      add_row(OP_TEST, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd0, CC_NC, 1'b0, '0);
      add_row(OP_OR, 32'h0, 32'h0, 8'd0, CC_NC, 1'b0, '0);
      add_row(OP_XOR, 32'hFFFF_FFFF, 32'h0F0F_0F0F, 8'd0, CC_NC, 1'b0, '0);
      add_row(OP_SHL, 32'h8000_0001, 32'h0, 8'd0, CC_NC, 1'b0, '0);
      add_row(OP_SHL, 32'hC000_0000, 32'h0, 8'd1, CC_NC, 1'b0, '0);
      add_row(OP_SHL, 32'h0000_0001, 32'h0, 8'hFF, CC_NC, 1'b0, '0);
      add_row(OP_SAR, 32'h8000_0000, 32'h0, 8'd1, CC_NC, 1'b0, '0);
      add_row(OP_SAR, 32'h8000_0000, 32'h0, 8'd31, CC_NC, 1'b0, '0);
      add_row(OP_SHR, 32'h8000_0000, 32'h0, 8'd1, CC_NC, 1'b0, '0);
      add_row(OP_JCC, 32'h0, 32'hFFFF_0000, 8'd0, CC_CXZ, 1'b0, '0);
      add_row(OP_JCC, 32'h0, 32'hFFFF_0000, 8'd0, CC_ECXZ, 1'b0, '0);
      add_row(OP_JCC, 32'h0, 32'h0, 8'd0, CC_ECXZ, 1'b0, '0);
      add_row(OP_JCC, 32'h0, 32'h0, 8'd0, CondUnused, 1'b0, '0);
      add_row(OP_JCC, 32'h0, 32'h0, 8'd0, CC_LE, 1'b0, '0);

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_op(directed_rows[i].op, directed_rows[i].dst, directed_rows[i].src,
                 directed_rows[i].count, directed_rows[i].cc, directed_rows[i].typed,
                 directed_rows[i].answer);
         idle_gap(pick_gap());
      end

      for (int g = 0; g < RandomGroups; g++) begin
         no_gaps = ($urandom_range(0, 3) == 0);
         for (int k = 0; k < GroupSize; k++) begin
            send_op(($urandom_range(0, 99) < 94) ? OpWidth'($urandom_range(0, 11))
                                                 : OpWidth'($urandom_range(12, 15)),
                    pick_operand(), pick_operand(),
                    ($urandom_range(0, 3) == 0) ? CountWidth'($urandom_range(0, 2))
                                                : CountWidth'($urandom_range(0, 255)),
                    ($urandom_range(0, 9) == 0) ? CondWidth'($urandom_range(18, 31))
                                                : CondWidth'($urandom_range(0, 17)),
                    1'b0, '0);
            gap = no_gaps ? 0 : pick_gap();
            idle_gap(gap);
         end
      end
      req_valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0 && pending_results.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // Result side: random stalls, plus one long hold so the unit fills and backs up.
   initial begin : result_sink
      int r;
      int stall;
      for (int round = 0; ; round++) begin
         r = $urandom_range(0, 99);
         if (round == 25) stall = 300;
         else if (r < 55) stall = 0;
         else if (r < 85) stall = $urandom_range(1, 4);
         else if (r < 97) stall = $urandom_range(5, 15);
         else stall = $urandom_range(20, 40);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat (($urandom_range(0, 7) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12))
            @(posedge clock);
      end
   end

   // Transfers are checked mid-cycle; the edge that follows completes them.
   always @(negedge clock) begin : result_check
      rsp_type seen;
      rsp_type wanted;
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_result_value, rsp_writes_back, rsp_parity_flag, rsp_zero_flag,
                 rsp_sign_flag, rsp_overflow_flag, rsp_carry_flag, rsp_branch_taken};
         if (pending_results.size() == 0) begin
            error_count++;
            if (error_count <= MaxReported)
               $display("unexpected transfer: value %h wb %b flags %b br %b",
                        seen.result_value, seen.writes_back, seen.flags, seen.branch_taken);
         end else begin
            wanted = pending_results.pop_front();
            if (seen.result_value !== wanted.result_value ||
                seen.writes_back !== wanted.writes_back ||
                seen.flags.cf !== wanted.flags.cf || seen.flags.of !== wanted.flags.of ||
                seen.flags.sf !== wanted.flags.sf || seen.flags.zf !== wanted.flags.zf ||
                seen.flags.pf !== wanted.flags.pf ||
                seen.branch_taken !== wanted.branch_taken) begin
               error_count++;
               if (error_count <= MaxReported)
                  $display("mismatch: exp value %h wb %b pzsoc %b br %b, got %h %b %b %b",
                           wanted.result_value, wanted.writes_back, wanted.flags,
                           wanted.branch_taken, seen.result_value, seen.writes_back,
                           seen.flags, seen.branch_taken);
            end
         end
      end
   end

   initial begin
      #2_000_000;
      $display("Regression FAIL");
      $finish;
   end

endmodule

`default_nettype wire
